/* hdl/slis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slis_pkg;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FOUND    = 2'd1,
      ST_MISSING  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_UPDATE = 1'b1
   } fsm_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] position;
      logic [4:0] count;
   } rsp_type;

   // cell strobes from the sequencer, shared by all cells
   typedef struct packed {
      logic capture;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* hdl/slis_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module slis_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  slis_pkg::cell_ctrl_type   ctrl,
   input  wire                       holds,
   input  wire  signed [31:0]        probe,
   input  wire  signed [31:0]        key,
   input  wire  signed [31:0]        prev_value,
   input  wire                       prev_lt,
   output logic signed [31:0]        value,
   output logic                      lt,
   output logic                      eq
);

   logic signed [31:0] value_ff, value_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.capture) begin
         lt_in = holds && (value_ff < probe);
         eq_in = holds && (value_ff == probe);
      end
   end

   // thermometer of lt flags: cells below the slot keep, the slot takes the key,
   // cells above take the neighbor's value
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift && !lt_ff) begin
         if (prev_lt) begin
            value_in = key;
         end else begin
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

`ifndef SYNTHESIS
   a_lt_thermo: assert property (@(posedge clock) disable iff (reset)
      lt_ff |-> prev_lt)
      else $error("lt flags not a thermometer");
   a_lt_eq_excl: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> !(lt_ff && eq_ff))
      else $error("cell both less and equal");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      !ctrl.shift |=> $stable(value_ff))
      else $error("cell value moved without shift");
`endif

endmodule

`default_nettype wire

/* hdl/sorted_list_insert_search_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted insertion list: a row of DEPTH cells keeps signed 32-bit values ascending.
// Request channel (req_valid/req_ready/req_data): cmd insert or search plus value.
// Response channel (rsp_valid/rsp_ready/rsp_data): status, position, count; one
// response beat per request beat, in order.
// Each request is handled in two steps: in the accept cycle every cell compares its value
// against the request; in the update state the flags are encoded into a slot and, on
// an insert, every cell above the slot takes its lower neighbor's value at once.
// A new request is not taken until the update of the last one is done.
// Response appears in rsp_data the cycle after the update.
// Insert places the value before the first entry greater or equal; an insert into
// a full list is dropped with status full. A search reports the first match.
// Reset empties the list (count zero); no clearing pass.
// The response sits in an output register: a new request is taken while it waits;
// if rsp_ready stays low the next update holds until the register frees up.
module sorted_list_insert_search_core #(
   parameter int DEPTH = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  slis_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output slis_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PW    = (IDX_W > 4) ? IDX_W : 4;
   localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

   slis_pkg::fsm_type       state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   slis_pkg::cmd_type       cmd_ff;
   logic signed [31:0]      key_ff;
   slis_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   slis_pkg::cell_ctrl_type ctrl;
   logic                    accept;
   logic                    finish;
   logic                    full;
   logic                    found;
   logic [IDX_W-1:0]        slot;
   logic [PW-1:0]           slot_ext;
   logic [CW-1:0]           count_ext;

   logic signed [31:0]      cell_value [DEPTH];
   logic [DEPTH-1:0]        cell_lt;
   logic [DEPTH-1:0]        cell_eq;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slis_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = slis_pkg::FSM_UPDATE;
            end
         end
         slis_pkg::FSM_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = slis_pkg::FSM_IDLE;
            end
         end
         default: state_in = slis_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         slis_pkg::FSM_IDLE:   req_ready = 1'b1;
         slis_pkg::FSM_UPDATE: finish    = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            finish    = 1'b0;
         end
      endcase
   end

   assign accept       = req_valid && req_ready;
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign ctrl.capture = accept;
   assign ctrl.shift   = finish && (cmd_ff == slis_pkg::CMD_INSERT) && !full;

   // ---------------- cell row ----------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] prev_value;
      logic               prev_lt;
      if (i == 0) begin : g_first
         assign prev_value = key_ff;
         assign prev_lt    = 1'b1;
      end else begin : g_rest
         assign prev_value = cell_value[i-1];
         assign prev_lt    = cell_lt[i-1];
      end

      slis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .holds      (count_ff > CNT_W'(i)),
         .probe      (req_data.value),
         .key        (key_ff),
         .prev_value (prev_value),
         .prev_lt    (prev_lt),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .eq         (cell_eq[i])
      );
   end

   // slot = edge of the lt thermometer; first match of a search lands on it too
   always_comb begin
      slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (!cell_lt[i] && ((i == 0) || cell_lt[(i == 0) ? 0 : i - 1])) begin
            slot = slot | IDX_W'(i);
         end
      end
   end

   assign found    = |cell_eq;
   assign slot_ext = PW'(slot);

   // ---------------- result ----------------
   always_comb begin
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      count_ext = '0;
      if (finish) begin
         if (cmd_ff == slis_pkg::CMD_INSERT) begin
            if (full) begin
               rsp_in.status   = slis_pkg::ST_FULL;
               rsp_in.position = '0;
            end else begin
               count_in        = count_ff + CNT_W'(1);
               rsp_in.status   = slis_pkg::ST_INSERTED;
               rsp_in.position = slot_ext[3:0];
            end
         end else if (found) begin
            rsp_in.status   = slis_pkg::ST_FOUND;
            rsp_in.position = slot_ext[3:0];
         end else begin
            rsp_in.status   = slis_pkg::ST_MISSING;
            rsp_in.position = '0;
         end
         count_ext    = CW'(count_in);
         rsp_in.count = count_ext[4:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slis_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         cmd_ff <= req_data.cmd;
         key_ff <= req_data.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.shift |=> $stable(count_ff))
      else $error("fill count moved without insert");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second request taken during update");
   a_found_edge: assert property (@(posedge clock) disable iff (reset)
      (finish && found) |-> $onehot(cell_eq & ~cell_lt & ({cell_lt[DEPTH-2:0], 1'b1})))
      else $error("match not at slot edge");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 2000;
   localparam int FULL_ITEMS = 1830;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   slis_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   slis_pkg::rsp_type rsp_data;

   // shadow copy of the list contents, updated on every accepted request beat
   logic signed [31:0] held_vals [DEPTH];
   int                 held_count = 0;
   slis_pkg::rsp_type  owed_replies[$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  inserts_sent   = 0;
   bit  send_gaps_on   = 1'b1;
   bit  stall_on       = 1'b1;
   int  stall_left     = 0;

   sorted_list_insert_search_core #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // insert lands before the first entry >= value; search reports first match
   function automatic slis_pkg::rsp_type apply_list_op(input slis_pkg::req_type r);
      slis_pkg::rsp_type  o;
      logic signed [31:0] v;
      int                 slot;
      int                 i;
      v = r.value;
      o = '0;
      if (r.cmd == slis_pkg::CMD_INSERT) begin
         if (held_count >= DEPTH) begin
            o.status = slis_pkg::ST_FULL;
         end else begin
            slot = held_count;
            for (i = 0; i < held_count; i++) begin
               if (held_vals[i] >= v) begin
                  slot = i;
                  break;
               end
            end
            for (i = held_count; i > slot; i--)
               held_vals[i] = held_vals[i - 1];
            held_vals[slot] = v;
            held_count++;
            o.status   = slis_pkg::ST_INSERTED;
            o.position = slot[3:0];
         end
      end else begin
         o.status = slis_pkg::ST_MISSING;
         for (i = 0; i < held_count; i++) begin
            if (held_vals[i] == v) begin
               o.status   = slis_pkg::ST_FOUND;
               o.position = i[3:0];
               break;
            end
         end
      end
      o.count = held_count[4:0];
      return o;
   endfunction

   // response side back-pressure
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
      if (stall_left == 0 && stall_on) stall_left = random_gap();
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // request beats feed the shadow list, response beats are checked in order
   always @(posedge clock) begin
      slis_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            owed_replies.push_back(apply_list_op(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               $display("%0t: response beat with nothing owed, got status %0d pos %0d count %0d",
                        $time, rsp_data.status, rsp_data.position, rsp_data.count);
               mismatch_count++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.position !== want.position) begin
                  $display("%0t: position expected %0d got %0d",
                           $time, want.position, rsp_data.position);
                  mismatch_count++;
               end
               if (rsp_data.count !== want.count) begin
                  $display("%0t: count expected %0d got %0d",
                           $time, want.count, rsp_data.count);
                  mismatch_count++;
               end
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d responses still owed", $time, owed_replies.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // caller sits on a rising edge; returns on the edge that takes the beat
   task automatic send_beat(input slis_pkg::cmd_type c, input logic signed [31:0] v);
      int gap;
      gap = send_gaps_on ? random_gap() : 0;
      if (gap > 0) begin
         req_valid      <= 1'b0;
         req_data.cmd   <= slis_pkg::cmd_type'($urandom_range(0, 1));
         req_data.value <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data.cmd   <= c;
      req_data.value <= v;
      if (c == slis_pkg::CMD_INSERT) inserts_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   // pick a value that is likely to sit in or next to the list
   function automatic logic signed [31:0] near_held_value();
      int r;
      int k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, DEPTH - 1);
      if (r < 45) return held_vals[k];
      if (r < 60) return held_vals[k] + ($urandom_range(0, 1) ? 1 : -1);
      return $urandom;
   endfunction

   task automatic test_empty_search();
      send_beat(slis_pkg::CMD_SEARCH, 32'sd0);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh7fff_ffff);
   endtask

   task automatic test_extremes_and_dups();
      send_beat(slis_pkg::CMD_INSERT, 32'sh7fff_ffff);
      send_beat(slis_pkg::CMD_INSERT, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_INSERT, 32'sd0);
      send_beat(slis_pkg::CMD_INSERT, -32'sd1);
      send_beat(slis_pkg::CMD_INSERT, 32'sd0);          // equal value goes in front
      send_beat(slis_pkg::CMD_INSERT, 32'sh7fff_ffff);
      send_beat(slis_pkg::CMD_INSERT, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh7fff_ffff);
      send_beat(slis_pkg::CMD_SEARCH, 32'sd0);
      send_beat(slis_pkg::CMD_SEARCH, -32'sd1);
      send_beat(slis_pkg::CMD_SEARCH, 32'sd1);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh7fff_fffe);
   endtask

   // small value pool so duplicates and equal compares show up often
   task automatic test_random_fill();
      logic signed [31:0] v;
      while (inserts_sent < DEPTH - 1) begin
         v = $urandom_range(0, 1) ? $signed($urandom_range(0, 6)) - 3 : $signed($urandom);
         send_beat($urandom_range(0, 1) ? slis_pkg::CMD_INSERT : slis_pkg::CMD_SEARCH, v);
      end
   endtask

   task automatic test_full_insert();
      send_beat(slis_pkg::CMD_INSERT, 32'sd2);
      send_beat(slis_pkg::CMD_INSERT, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_INSERT, 32'sh7fff_ffff);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh8000_0000);
      send_beat(slis_pkg::CMD_SEARCH, 32'sh7fff_ffff);
   endtask

   // list is full from here on: mostly lookups, some dropped inserts
   task automatic test_random_full();
      int n;
      for (n = 0; n < FULL_ITEMS; n++) begin
         if ($urandom_range(0, 99) == 0) send_gaps_on = !send_gaps_on;
         if ($urandom_range(0, 4) == 0) send_beat(slis_pkg::CMD_INSERT, $urandom);
         else send_beat(slis_pkg::CMD_SEARCH, near_held_value());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_search();
      test_extremes_and_dups();
      test_random_fill();
      test_full_insert();
      test_random_full();
      req_valid <= 1'b0;
      // let the monitor log the last request beat before draining
      @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/slis_pkg.sv
hdl/slis_cell.sv
hdl/sorted_list_insert_search_core.sv
tb/tb_top.sv
